// ===== hdl/script_token_lexer_macros.svh =====
// Assertion macros for the script token lexer.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef SCRIPT_TOKEN_LEXER_MACROS_SVH
`define SCRIPT_TOKEN_LEXER_MACROS_SVH

// The consequent must hold in the same cycle as the condition.
`define STL_ASSERT_IMP(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("script_token_lexer: same-cycle check failed");

// The consequent must hold in the cycle after the condition.
`define STL_ASSERT_NEXT(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("script_token_lexer: next-cycle check failed");

`endif

// ===== hdl/stl_pkg.sv =====
// Shared types, constants and byte classification for the script token lexer.
// Used by the front end, the group queue, the back end and the top level.
package stl_pkg;

	localparam int POS_BITS = 32;
	localparam int QUEUE_DEPTH = 4;
	localparam int GROUP_SLOTS = 3;
	localparam int SLOT_CNT_BITS = $clog2(GROUP_SLOTS + 1);
	localparam int SLOT_IDX_BITS = $clog2(GROUP_SLOTS);

	typedef logic [POS_BITS-1:0] pos_t;

	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_EQ = 8'h3d;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_DOT = 8'h2e;
	localparam logic [7:0] CH_LF = 8'h0a;
	localparam logic [7:0] CH_CR = 8'h0d;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_UNDERSCORE = 8'h5f;
	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_OPEN_PAREN = 8'h28;
	localparam logic [7:0] CH_CLOSE_PAREN = 8'h29;
	localparam logic [7:0] CH_COMMA = 8'h2c;
	localparam logic [7:0] CH_OPEN_BRACE = 8'h7b;
	localparam logic [7:0] CH_CLOSE_BRACE = 8'h7d;
	localparam logic [7:0] CH_BANG = 8'h21;
	localparam logic [7:0] CH_LESS = 8'h3c;
	localparam logic [7:0] CH_GREATER = 8'h3e;
	localparam logic [7:0] CH_PLUS = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_STAR = 8'h2a;
	localparam logic [7:0] CH_SLASH = 8'h2f;

	typedef enum logic [4:0] {
		K_COMMENT       = 5'd0,
		K_WORD          = 5'd1,
		K_MEMBER        = 5'd2,
		K_NUMBER        = 5'd3,
		K_TEXT          = 5'd4,
		K_NOT           = 5'd5,
		K_LESS          = 5'd6,
		K_GREATER       = 5'd7,
		K_ASSIGN        = 5'd8,
		K_EQUAL         = 5'd9,
		K_NOT_EQUAL     = 5'd10,
		K_LESS_EQUAL    = 5'd11,
		K_GREATER_EQUAL = 5'd12,
		K_ADD           = 5'd13,
		K_SUBTRACT      = 5'd14,
		K_MULTIPLY      = 5'd15,
		K_DIVIDE        = 5'd16,
		K_OPEN_PAREN    = 5'd17,
		K_CLOSE_PAREN   = 5'd18,
		K_COMMA         = 5'd19,
		K_OPEN_BRACE    = 5'd20,
		K_CLOSE_BRACE   = 5'd21,
		K_END           = 5'd22,
		K_UNKNOWN       = 5'd23
	} kind_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       has_char;
		logic       is_last;
	} item_t;

	typedef struct packed {
		kind_t       token_kind;
		logic [31:0] token_offset;
		logic [31:0] token_length;
		logic        run_last;
	} token_t;

	typedef struct packed {
		logic [SLOT_CNT_BITS-1:0]  count;
		token_t [GROUP_SLOTS-1:0]  slot;
	} group_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_word(input logic [7:0] c);
		return is_digit(c) || ((c >= 8'h61) && (c <= 8'h7a)) ||
			((c >= 8'h41) && (c <= 8'h5a)) || (c == CH_UNDERSCORE);
	endfunction

	function automatic pos_t sat_inc(input pos_t v);
		return (v == '1) ? v : v + pos_t'(1);
	endfunction

	function automatic kind_t classify(input logic [7:0] c);
		kind_t k;
		case (c)
			CH_HASH:        k = K_COMMENT;
			CH_OPEN_PAREN:  k = K_OPEN_PAREN;
			CH_CLOSE_PAREN: k = K_CLOSE_PAREN;
			CH_COMMA:       k = K_COMMA;
			CH_OPEN_BRACE:  k = K_OPEN_BRACE;
			CH_CLOSE_BRACE: k = K_CLOSE_BRACE;
			CH_EQ:          k = K_ASSIGN;
			CH_BANG:        k = K_NOT;
			CH_LESS:        k = K_LESS;
			CH_GREATER:     k = K_GREATER;
			CH_PLUS:        k = K_ADD;
			CH_MINUS:       k = K_SUBTRACT;
			CH_STAR:        k = K_MULTIPLY;
			CH_SLASH:       k = K_DIVIDE;
			CH_DQUOTE:      k = K_TEXT;
			CH_SQUOTE:      k = K_TEXT;
			CH_DOT:         k = K_MEMBER;
			default: begin
				if (is_digit(c))
					k = K_NUMBER;
				else if (is_word(c))
					k = K_WORD;
				else
					k = K_UNKNOWN;
			end
		endcase
		return k;
	endfunction

endpackage

// ===== hdl/stl_front.sv =====
// Front end of the script token lexer: holds the open token and the text flags,
// classifies each byte and forms the group of tokens it closes. Uses stl_pkg.
module stl_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  stl_pkg::item_t  item,
	output stl_pkg::group_t grp
);
	import stl_pkg::*;

	logic  token_open_q;
	kind_t open_kind_q;
	pos_t  open_start_q;
	pos_t  open_length_q;
	pos_t  position_q;
	logic  escape_pending_q;
	logic  quote_single_q;
	logic  text_closed_q;

	logic  open_d;
	kind_t kind_d;
	pos_t  start_d;
	pos_t  len_d;
	pos_t  pos_d;
	logic  esc_d;
	logic  quote_d;
	logic  closed_d;

	logic  closes;
	logic  close;
	logic  open_mid;
	logic  space_byte;
	logic  e_close;
	logic  e_flush;
	logic  e_end;
	logic [SLOT_CNT_BITS-1:0] fill;
	token_t t_close;
	token_t t_flush;
	token_t t_end;

	always_comb begin
		case (open_kind_q)
			K_COMMENT: closes = (item.ch == CH_LF) || (item.ch == CH_NUL);
			K_WORD, K_MEMBER: closes = !is_word(item.ch);
			K_NUMBER: closes = !is_digit(item.ch);
			K_TEXT: closes = text_closed_q;
			K_NOT, K_LESS, K_GREATER, K_ASSIGN: closes = (item.ch != CH_EQ);
			default: closes = 1'b1;
		endcase
	end

	assign close = token_open_q && closes;
	assign open_mid = token_open_q && !closes;
	assign space_byte = (item.ch == CH_SPACE) || (item.ch == CH_CR) || (item.ch == CH_LF);

	always_comb begin
		open_d = token_open_q;
		kind_d = open_kind_q;
		start_d = open_start_q;
		len_d = open_length_q;
		pos_d = position_q;
		esc_d = escape_pending_q;
		quote_d = quote_single_q;
		closed_d = text_closed_q;
		if (item.has_char) begin
			pos_d = sat_inc(position_q);
			if (close)
				open_d = 1'b0;
			if (!open_mid) begin
				if (!space_byte) begin
					open_d = 1'b1;
					kind_d = classify(item.ch);
					start_d = position_q;
					len_d = pos_t'(1);
					quote_d = (item.ch == CH_SQUOTE);
					esc_d = 1'b0;
					closed_d = 1'b0;
				end
			end else begin
				if (item.ch == CH_EQ) begin
					case (open_kind_q)
						K_ASSIGN:  kind_d = K_EQUAL;
						K_NOT:     kind_d = K_NOT_EQUAL;
						K_LESS:    kind_d = K_LESS_EQUAL;
						K_GREATER: kind_d = K_GREATER_EQUAL;
						default:   kind_d = open_kind_q;
					endcase
				end
				if (open_kind_q == K_TEXT) begin
					if (escape_pending_q) begin
						esc_d = 1'b0;
						closed_d = 1'b0;
					end else if (item.ch == CH_BSLASH) begin
						esc_d = 1'b1;
						closed_d = 1'b0;
					end else begin
						closed_d = (item.ch == (quote_single_q ? CH_SQUOTE : CH_DQUOTE));
					end
				end
				len_d = sat_inc(open_length_q);
			end
		end
	end

	assign e_close = item.has_char && close;
	assign e_flush = item.is_last && open_d;
	assign e_end = item.is_last;

	always_comb begin
		t_close.token_kind = open_kind_q;
		t_close.token_offset = 32'(open_start_q);
		t_close.token_length = 32'(open_length_q);
		t_close.run_last = !e_flush && !e_end;
		t_flush.token_kind = kind_d;
		t_flush.token_offset = 32'(start_d);
		t_flush.token_length = 32'(len_d);
		t_flush.run_last = !e_end;
		t_end.token_kind = K_END;
		t_end.token_offset = 32'(pos_d);
		t_end.token_length = 32'd0;
		t_end.run_last = 1'b1;
	end

	always_comb begin
		grp = '0;
		fill = '0;
		if (e_close) begin
			grp.slot[fill] = t_close;
			fill = fill + 1'b1;
		end
		if (e_flush) begin
			grp.slot[fill] = t_flush;
			fill = fill + 1'b1;
		end
		if (e_end) begin
			grp.slot[fill] = t_end;
			fill = fill + 1'b1;
		end
		grp.count = fill;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_open_q <= 1'b0;
			open_kind_q <= K_COMMENT;
			open_start_q <= '0;
			open_length_q <= '0;
			position_q <= '0;
			escape_pending_q <= 1'b0;
			quote_single_q <= 1'b0;
			text_closed_q <= 1'b0;
		end else if (accept) begin
			if (item.is_last) begin
				token_open_q <= 1'b0;
				open_kind_q <= K_COMMENT;
				open_start_q <= '0;
				open_length_q <= '0;
				position_q <= '0;
				escape_pending_q <= 1'b0;
				quote_single_q <= 1'b0;
				text_closed_q <= 1'b0;
			end else begin
				token_open_q <= open_d;
				open_kind_q <= kind_d;
				open_start_q <= start_d;
				open_length_q <= len_d;
				position_q <= pos_d;
				escape_pending_q <= esc_d;
				quote_single_q <= quote_d;
				text_closed_q <= closed_d;
			end
		end
	end

endmodule

// ===== hdl/stl_queue.sv =====
// Short queue of token groups between the front end and the back end.
// One group written per cycle while not full and one read while not empty. Uses stl_pkg.
module stl_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr,
	input  stl_pkg::group_t    wdata,
	input  logic               rd,
	output stl_pkg::group_t    rdata,
	output stl_pkg::q_status_t status
);
	import stl_pkg::*;

	localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
	localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

	group_t mem_q [QUEUE_DEPTH];
	logic [PTR_BITS-1:0] wptr_q;
	logic [PTR_BITS-1:0] rptr_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic do_wr;
	logic do_rd;

	assign status.full = (cnt_q == CNT_BITS'(QUEUE_DEPTH));
	assign status.empty = (cnt_q == '0);
	assign do_wr = wr && !status.full;
	assign do_rd = rd && !status.empty;
	assign rdata = mem_q[rptr_q];

	function automatic logic [PTR_BITS-1:0] next_ptr(input logic [PTR_BITS-1:0] p);
		return (p == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr)
				wptr_q <= next_ptr(wptr_q);
			if (do_rd)
				rptr_q <= next_ptr(rptr_q);
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ===== hdl/stl_back.sv =====
// Back end of the script token lexer: takes one group at a time from the queue
// and hands its tokens to the output one per cycle while pop is high. Uses stl_pkg.
module stl_back (
	input  logic               clk,
	input  logic               arst_n,
	input  stl_pkg::q_status_t qstat,
	input  stl_pkg::group_t    head,
	output logic               qpop,
	input  logic               pop,
	output logic               empty,
	output stl_pkg::token_t    token
);
	import stl_pkg::*;

	group_t cur_q;
	logic [SLOT_IDX_BITS-1:0] idx_q;
	logic valid_q;
	logic take;
	logic advance;

	assign token = cur_q.slot[idx_q];
	assign empty = !valid_q;
	assign take = pop && valid_q;
	assign advance = !valid_q || (take && token.run_last);
	assign qpop = advance && !qstat.empty;

	always_ff @(posedge clk) begin
		if (qpop)
			cur_q <= head;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q <= '0;
		end else if (advance) begin
			valid_q <= !qstat.empty;
			idx_q <= '0;
		end else if (take) begin
			idx_q <= idx_q + 1'b1;
		end
	end

endmodule

// ===== hdl/script_token_lexer.sv =====
// Top level of the script token lexer: front end, group queue and back end.
// Depends on stl_pkg, stl_front, stl_queue, stl_back and the assertion macros.
//
// Source bytes enter through a queue-style port: a transaction is taken at a
// rising edge where push is high and full is low. Tokens leave the same way:
// while empty is low the oldest token is on the token port, and a transaction
// completes at an edge where pop is high and empty is low.
// Each byte may close up to three tokens (the closed token, the flushed open
// token and the end token on the last byte); they travel as one group through
// a four-entry queue, and run_last marks the final token of a group.
// With the back end idle, the group of a byte is registered in the queue entry
// and then in the back-end group register before it reaches the token port.
// Throughput: one byte per cycle in while full is low and one token per cycle
// out while pop is high and empty is low; the front update is combinational
// classification, and the queue absorbs bursts of several tokens per byte.
// When the consumer stalls, tokens wait in the back end and the queue; full
// rises once the queue holds four groups and input is held until space frees.
// Reset clears the lexer state, the queue and the output stage at once.
`include "script_token_lexer_macros.svh"

module script_token_lexer (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  stl_pkg::item_t  item,
	output logic            empty,
	input  logic            pop,
	output stl_pkg::token_t token
);
	import stl_pkg::*;

	group_t    grp;
	group_t    head;
	q_status_t qstat;
	logic      accept;
	logic      grp_wr;
	logic      qpop;

	assign full = qstat.full;
	assign accept = push && !qstat.full;
	assign grp_wr = accept && (grp.count != '0);

	stl_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (item),
		.grp    (grp)
	);

	stl_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (grp_wr),
		.wdata  (grp),
		.rd     (qpop),
		.rdata  (head),
		.status (qstat)
	);

	stl_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.qstat  (qstat),
		.head   (head),
		.qpop   (qpop),
		.pop    (pop),
		.empty  (empty),
		.token  (token)
	);

	`STL_ASSERT_IMP(a_last_writes_group, accept && item.is_last, grp_wr)
	`STL_ASSERT_IMP(a_idle_item_silent, accept && !item.has_char && !item.is_last, !grp_wr)
	`STL_ASSERT_NEXT(a_last_reaches_queue, accept && item.is_last, !qstat.empty || !empty)

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for script_token_lexer: drives source bytes through the input
// queue, predicts the token stream and checks every token on the output queue.
// Depends on stl_pkg and the script_token_lexer RTL.
module tb_top;
	import stl_pkg::*;

	logic clk;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	item_t item = '0;
	logic empty;
	logic pop = 1'b0;
	token_t token;

	token_t due_tokens[$];
	logic [7:0] src_buf[$];
	int err_count = 0;

	logic in_idle_on = 1'b1;
	logic out_idle_on = 1'b1;
	int stall_req = 0;
	int stall_seen = 0;
	int stall_left = 0;

	string ident_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
	string cmp_chars = "!<>=";
	string punct_chars = "+-*/(),{}";
	string space_chars = " \r\n";

	logic in_token = 1'b0;
	kind_t cur_kind = K_COMMENT;
	logic [31:0] cur_start = '0;
	logic [31:0] cur_len = '0;
	logic [31:0] byte_pos = '0;
	logic esc_armed = 1'b0;
	logic single_quoted = 1'b0;
	logic quote_seen = 1'b0;

	script_token_lexer DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (full),
		.item  (item),
		.empty (empty),
		.pop   (pop),
		.token (token)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	initial begin
		#2_000_000;
		$display("tb_top: errors");
		$finish;
	end

	function automatic logic dec_byte(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic ident_byte(input logic [7:0] c);
		return dec_byte(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
			c == CH_UNDERSCORE;
	endfunction

	function automatic logic [31:0] bump(input logic [31:0] v);
		return (v == '1) ? v : v + 32'd1;
	endfunction

	function automatic kind_t kind_of(input logic [7:0] c);
		case (c)
			CH_HASH: return K_COMMENT;
			CH_OPEN_PAREN: return K_OPEN_PAREN;
			CH_CLOSE_PAREN: return K_CLOSE_PAREN;
			CH_COMMA: return K_COMMA;
			CH_OPEN_BRACE: return K_OPEN_BRACE;
			CH_CLOSE_BRACE: return K_CLOSE_BRACE;
			CH_EQ: return K_ASSIGN;
			CH_BANG: return K_NOT;
			CH_LESS: return K_LESS;
			CH_GREATER: return K_GREATER;
			CH_PLUS: return K_ADD;
			CH_MINUS: return K_SUBTRACT;
			CH_STAR: return K_MULTIPLY;
			CH_SLASH: return K_DIVIDE;
			CH_DQUOTE, CH_SQUOTE: return K_TEXT;
			CH_DOT: return K_MEMBER;
			default: ;
		endcase
		if (dec_byte(c))
			return K_NUMBER;
		if (ident_byte(c))
			return K_WORD;
		return K_UNKNOWN;
	endfunction

	function automatic logic token_ends(input logic [7:0] c);
		case (cur_kind)
			K_COMMENT: return c == CH_LF || c == CH_NUL;
			K_WORD, K_MEMBER: return !ident_byte(c);
			K_NUMBER: return !dec_byte(c);
			K_TEXT: return quote_seen;
			K_NOT, K_LESS, K_GREATER, K_ASSIGN: return c != CH_EQ;
			default: return 1'b1;
		endcase
	endfunction

	function automatic token_t make_token(input kind_t k, input logic [31:0] off,
		input logic [31:0] len);
		token_t t;
		t.token_kind = k;
		t.token_offset = off;
		t.token_length = len;
		t.run_last = 1'b0;
		return t;
	endfunction

	function automatic item_t pack_item(input logic [7:0] c, input logic has, input logic last);
		item_t it;
		it.ch = c;
		it.has_char = has;
		it.is_last = last;
		return it;
	endfunction

	function automatic void add_src(input logic [7:0] b);
		src_buf.insert(src_buf.size(), b);
	endfunction

	// Advances the lexer state by one input transaction and queues the tokens it closes.
	function automatic void lex_byte(input item_t it);
		token_t batch[3];
		token_t t;
		int n;
		logic [7:0] c;
		n = 0;
		c = it.ch;
		if (it.has_char) begin
			if (in_token && token_ends(c)) begin
				batch[n] = make_token(cur_kind, cur_start, cur_len);
				n++;
				in_token = 1'b0;
			end
			if (!in_token) begin
				if (!(c == CH_SPACE || c == CH_CR || c == CH_LF)) begin
					in_token = 1'b1;
					cur_kind = kind_of(c);
					cur_start = byte_pos;
					cur_len = 32'd1;
					single_quoted = (c == CH_SQUOTE);
					esc_armed = 1'b0;
					quote_seen = 1'b0;
				end
			end else begin
				if (c == CH_EQ) begin
					case (cur_kind)
						K_ASSIGN: cur_kind = K_EQUAL;
						K_NOT: cur_kind = K_NOT_EQUAL;
						K_LESS: cur_kind = K_LESS_EQUAL;
						K_GREATER: cur_kind = K_GREATER_EQUAL;
						default: ;
					endcase
				end
				if (cur_kind == K_TEXT) begin
					if (esc_armed) begin
						esc_armed = 1'b0;
						quote_seen = 1'b0;
					end else if (c == CH_BSLASH) begin
						esc_armed = 1'b1;
						quote_seen = 1'b0;
					end else begin
						quote_seen = (c == (single_quoted ? CH_SQUOTE : CH_DQUOTE));
					end
				end
				cur_len = bump(cur_len);
			end
			byte_pos = bump(byte_pos);
		end
		if (it.is_last) begin
			if (in_token) begin
				batch[n] = make_token(cur_kind, cur_start, cur_len);
				n++;
			end
			batch[n] = make_token(K_END, byte_pos, 32'd0);
			n++;
			in_token = 1'b0;
			cur_kind = K_COMMENT;
			cur_start = '0;
			cur_len = '0;
			byte_pos = '0;
			esc_armed = 1'b0;
			single_quoted = 1'b0;
			quote_seen = 1'b0;
		end
		for (int i = 0; i < n; i++) begin
			t = batch[i];
			t.run_last = (i == n - 1);
			due_tokens.insert(due_tokens.size(), t);
		end
	endfunction

	task automatic report_error(input string msg);
		$display("tb_top: mismatch: %s", msg);
		err_count++;
	endtask

	always @(posedge clk) begin : check_tokens
		token_t want;
		if (arst_n && push && !full)
			lex_byte(item);
		if (arst_n && pop && !empty) begin
			if (due_tokens.size() == 0) begin
				report_error($sformatf("unexpected token kind %0d offset %0d",
					token.token_kind, token.token_offset));
			end else begin
				want = due_tokens.pop_front();
				if (token.token_kind !== want.token_kind)
					report_error($sformatf("kind %0d, want %0d at offset %0d",
						token.token_kind, want.token_kind, want.token_offset));
				if (token.token_offset !== want.token_offset)
					report_error($sformatf("offset %0d, want %0d",
						token.token_offset, want.token_offset));
				if (token.token_length !== want.token_length)
					report_error($sformatf("length %0d, want %0d at offset %0d",
						token.token_length, want.token_length, want.token_offset));
				if (token.run_last !== want.run_last)
					report_error($sformatf("run_last %b, want %b at offset %0d",
						token.run_last, want.run_last, want.token_offset));
			end
		end
	end

	// Pops at random (always with out_idle_on low), or holds off a long stretch when asked.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			pop <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (stall_seen != stall_req) begin
			stall_seen <= stall_req;
			stall_left <= 400;
			pop <= 1'b0;
		end else begin
			pop <= !(out_idle_on && $urandom_range(99) < 37);
		end
	end

	task automatic send_item(input item_t it);
		while (in_idle_on && $urandom_range(99) < 37) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= it;
		do @(posedge clk); while (full);
	endtask

	task automatic send_buf(input logic end_marker, output int sent);
		sent = 0;
		foreach (src_buf[i]) begin
			if ($urandom_range(99) < 5)
				send_item(pack_item(8'($urandom_range(255)), 1'b0, 1'b0));
			send_item(pack_item(src_buf[i], 1'b1, !end_marker && i == src_buf.size() - 1));
			sent++;
		end
		if (end_marker) begin
			send_item(pack_item(8'($urandom_range(255)), 1'b0, 1'b1));
			sent++;
		end
	endtask

	task automatic add_fragment();
		logic [7:0] q;
		case ($urandom_range(11))
			0, 1: begin
				add_src(ident_chars[$urandom_range(52)]);
				repeat ($urandom_range(5))
					add_src(ident_chars[$urandom_range(62)]);
			end
			2: begin
				repeat ($urandom_range(1, 4))
					add_src(8'h30 + 8'($urandom_range(9)));
			end
			3: begin
				add_src(CH_DOT);
				repeat ($urandom_range(4))
					add_src(ident_chars[$urandom_range(62)]);
			end
			4: begin
				q = $urandom_range(1) ? CH_SQUOTE : CH_DQUOTE;
				add_src(q);
				repeat ($urandom_range(5)) begin
					if ($urandom_range(99) < 20) begin
						add_src(CH_BSLASH);
						add_src(8'($urandom_range(255)));
					end else begin
						add_src(8'($urandom_range(32, 126)));
					end
				end
				if ($urandom_range(99) < 70)
					add_src(q);
			end
			5: begin
				add_src(CH_HASH);
				repeat ($urandom_range(6))
					add_src(8'($urandom_range(1, 255)));
				add_src($urandom_range(3) == 0 ? CH_NUL : CH_LF);
			end
			6: begin
				add_src(cmp_chars[$urandom_range(3)]);
				if ($urandom_range(1))
					add_src(CH_EQ);
			end
			7: add_src(punct_chars[$urandom_range(8)]);
			8, 9: begin
				repeat ($urandom_range(1, 2))
					add_src(space_chars[$urandom_range(2)]);
			end
			10: add_src(8'($urandom_range(255)));
			default: begin
				case ($urandom_range(3))
					0: add_src(8'h09);
					1: add_src(CH_NUL);
					2: add_src(8'h7f);
					default: add_src(8'($urandom_range(128, 255)));
				endcase
			end
		endcase
	endtask

	task automatic random_text(output int sent);
		int target;
		logic end_marker;
		src_buf.delete();
		target = $urandom_range(24);
		while (src_buf.size() < target)
			add_fragment();
		end_marker = (src_buf.size() == 0) || ($urandom_range(99) < 20);
		send_buf(end_marker, sent);
	endtask

	task automatic send_texts(input int item_goal);
		int sent;
		int total;
		total = 0;
		while (total < item_goal) begin
			random_text(sent);
			total += sent;
		end
	endtask

	task automatic test_directed();
		int sent;
		send_item(pack_item(8'hff, 1'b0, 1'b0));
		send_item(pack_item(8'h00, 1'b0, 1'b1));
		src_buf = '{CH_HASH, 8'h09, CH_NUL, 8'hff, CH_CR, CH_DQUOTE, CH_BSLASH, CH_DQUOTE,
			CH_DQUOTE, CH_DOT, CH_UNDERSCORE, CH_LF, CH_BANG, CH_EQ, CH_LESS, CH_GREATER,
			CH_EQ, CH_EQ, "9", "Z"};
		send_buf(1'b0, sent);
		src_buf = '{CH_SQUOTE, CH_SPACE, CH_BSLASH, CH_SQUOTE};
		send_buf(1'b0, sent);
	endtask

	task automatic test_random_texts();
		send_texts(300);
	endtask

	task automatic test_no_idle();
		in_idle_on = 1'b0;
		out_idle_on <= 1'b0;
		send_texts(80);
		in_idle_on = 1'b1;
		out_idle_on <= 1'b1;
	endtask

	task automatic test_backpressure();
		stall_req <= stall_req + 1;
		send_texts(60);
	endtask

	initial begin
		int drain_cycles;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_texts();
		test_no_idle();
		test_backpressure();
		push <= 1'b0;
		drain_cycles = 0;
		while (due_tokens.size() != 0 && drain_cycles < 5000) begin
			@(posedge clk);
			drain_cycles++;
		end
		repeat (10) @(posedge clk);
		if (due_tokens.size() != 0)
			report_error($sformatf("%0d tokens never arrived", due_tokens.size()));
		if (err_count == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule
